[sv/ubds_pkg.sv]
package ubds_pkg;

  localparam int CLK_W  = 27;
  localparam int BAUD_W = 24;
  localparam int OSR_W  = 6;
  localparam int DVS_W  = BAUD_W + OSR_W;
  localparam int ERR_W  = 27;

  localparam int DIVISOR_WIDTH_DEF  = 13;
  localparam int OVERSAMPLE_MAX_DEF = 32;

  localparam logic [OSR_W-1:0] OSR_MIN       = 6'd4;
  localparam logic [CLK_W-1:0] CLOCK_HZ_RST  = 27'd24000000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BASE,
    S_WAIT_BASE,
    S_PICK,
    S_WAIT_RATE,
    S_EVAL,
    S_FINISH
  } seq_state_t;

  typedef struct packed {
    logic             start;
    logic [CLK_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CLK_W-1:0] quotient;
  } div_rsp_t;

endpackage

[sv/ubds_if.sv]
interface ubds_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ubds_pkg::CLK_W-1:0] module_clock_hz;

  modport source (output valid, output module_clock_hz, input ready);
  modport sink (input valid, input module_clock_hz, output ready);
endinterface

interface ubds_in_if;
  logic                        valid;
  logic                        ready;
  logic [ubds_pkg::BAUD_W-1:0] target_baud;

  modport source (output valid, output target_baud, input ready);
  modport sink (input valid, input target_baud, output ready);
endinterface

interface ubds_out_if #(
  parameter int DIV_W = ubds_pkg::DIVISOR_WIDTH_DEF
);
  logic                       valid;
  logic                       ready;
  logic [DIV_W-1:0]           divisor;
  logic [ubds_pkg::OSR_W-1:0] oversample;
  logic [ubds_pkg::CLK_W-1:0] achieved_baud;
  logic [ubds_pkg::ERR_W-1:0] baud_error;
  logic                       found;
  logic                       exact;

  modport source (output valid, output divisor, output oversample, output achieved_baud,
                  output baud_error, output found, output exact, input ready);
  modport sink (input valid, input divisor, input oversample, input achieved_baud,
                input baud_error, input found, input exact, output ready);
endinterface

[sv/ubds_divider.sv]
module ubds_divider (
  input  logic               clk,
  input  logic               rst,
  input  ubds_pkg::div_req_t req,
  output ubds_pkg::div_rsp_t rsp
);
  import ubds_pkg::*;

  localparam int CNT_W = $clog2(CLK_W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CLK_W-1:0] quo;

  logic [DVS_W:0]   rem_sh;
  logic             ge;
  logic [DVS_W:0]   rem_sub;

  always_comb begin
    rem_sh  = {rem, quo[CLK_W-1]};
    ge      = rem_sh >= {1'b0, dvs};
    rem_sub = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(CLK_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvs <= req.divisor;
      quo <= req.dividend;
    end else if (busy) begin
      rem <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo <= {quo[CLK_W-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

[sv/ubds_seq.sv]
module ubds_seq #(
  parameter int DIVISOR_WIDTH  = ubds_pkg::DIVISOR_WIDTH_DEF,
  parameter int OVERSAMPLE_MAX = ubds_pkg::OVERSAMPLE_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ubds_pkg::BAUD_W-1:0] in_target,
  input  logic [ubds_pkg::CLK_W-1:0]  clock_hz,
  output ubds_pkg::div_req_t          div_req,
  input  ubds_pkg::div_rsp_t          div_rsp,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [DIVISOR_WIDTH-1:0]    res_divisor,
  output logic [ubds_pkg::OSR_W-1:0]  res_oversample,
  output logic [ubds_pkg::CLK_W-1:0]  res_achieved,
  output logic [ubds_pkg::ERR_W-1:0]  res_error,
  output logic                        res_found,
  output logic                        res_exact
);
  import ubds_pkg::*;

  localparam int PROD_W = DIVISOR_WIDTH + OSR_W;
  localparam logic [OSR_W-1:0] OSR_LAST  = OSR_W'(OVERSAMPLE_MAX);
  localparam logic [CLK_W:0]   DIV_LIMIT = (CLK_W + 1)'((1 << DIVISOR_WIDTH) - 1);

  seq_state_t state, state_next;

  logic [BAUD_W-1:0]        target, target_next;
  logic [CLK_W-1:0]         clk_hz, clk_hz_next;
  logic [OSR_W-1:0]         osr, osr_next;
  logic                     second, second_next;
  logic [CLK_W-1:0]         base_div, base_div_next;
  logic [DIVISOR_WIDTH-1:0] cand, cand_next;
  logic                     best_valid, best_valid_next;
  logic [DIVISOR_WIDTH-1:0] best_div, best_div_next;
  logic [OSR_W-1:0]         best_osr, best_osr_next;
  logic [CLK_W-1:0]         best_rate, best_rate_next;
  logic [ERR_W-1:0]         best_err, best_err_next;

  logic [OSR_W-1:0]         ratio;
  logic [CLK_W:0]           cand_wide;
  logic                     cand_ok;
  logic [PROD_W-1:0]        rate_prod;
  logic [ERR_W-1:0]         target_ext;
  logic [ERR_W-1:0]         err;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      best_valid <= 1'b0;
    end else begin
      state      <= state_next;
      best_valid <= best_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    target    <= target_next;
    clk_hz    <= clk_hz_next;
    osr       <= osr_next;
    second    <= second_next;
    base_div  <= base_div_next;
    cand      <= cand_next;
    best_div  <= best_div_next;
    best_osr  <= best_osr_next;
    best_rate <= best_rate_next;
    best_err  <= best_err_next;
  end

  always_comb begin
    ratio      = osr + 1'b1;
    cand_wide  = second ? ({1'b0, base_div} + 1'b1) : {1'b0, base_div};
    cand_ok    = (cand_wide != '0) && (cand_wide <= DIV_LIMIT);
    rate_prod  = PROD_W'(cand_wide[DIVISOR_WIDTH-1:0]) * PROD_W'(ratio);
    target_ext = ERR_W'(target);
    err        = (div_rsp.quotient >= target_ext) ? (div_rsp.quotient - target_ext)
                                                  : (target_ext - div_rsp.quotient);
  end

  always_comb begin
    state_next      = state;
    target_next     = target;
    clk_hz_next     = clk_hz;
    osr_next        = osr;
    second_next     = second;
    base_div_next   = base_div;
    cand_next       = cand;
    best_valid_next = best_valid;
    best_div_next   = best_div;
    best_osr_next   = best_osr;
    best_rate_next  = best_rate;
    best_err_next   = best_err;
    div_req.start    = 1'b0;
    div_req.dividend = clk_hz;
    div_req.divisor  = DVS_W'(target) * DVS_W'(ratio);
    in_ready  = 1'b0;
    res_valid = 1'b0;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          target_next     = in_target;
          clk_hz_next     = clock_hz;
          osr_next        = OSR_MIN;
          second_next     = 1'b0;
          best_valid_next = 1'b0;
          state_next      = (in_target == '0) ? S_FINISH : S_BASE;
        end
      end
      S_BASE: begin
        div_req.start = 1'b1;
        state_next    = S_WAIT_BASE;
      end
      S_WAIT_BASE: begin
        if (div_rsp.done) begin
          base_div_next = div_rsp.quotient;
          state_next    = S_PICK;
        end
      end
      S_PICK: begin
        if (cand_ok) begin
          div_req.start   = 1'b1;
          div_req.divisor = DVS_W'(rate_prod);
          cand_next       = cand_wide[DIVISOR_WIDTH-1:0];
          state_next      = S_WAIT_RATE;
        end else if (!second) begin
          second_next = 1'b1;
        end else if (osr == OSR_LAST) begin
          state_next = S_FINISH;
        end else begin
          osr_next    = osr + 1'b1;
          second_next = 1'b0;
          state_next  = S_BASE;
        end
      end
      S_WAIT_RATE: begin
        if (div_rsp.done) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!best_valid || err < best_err) begin
          best_valid_next = 1'b1;
          best_div_next   = cand;
          best_osr_next   = osr;
          best_rate_next  = div_rsp.quotient;
          best_err_next   = err;
        end
        if (err == '0) begin
          state_next = S_FINISH;
        end else if (!second) begin
          second_next = 1'b1;
          state_next  = S_PICK;
        end else if (osr == OSR_LAST) begin
          state_next = S_FINISH;
        end else begin
          osr_next    = osr + 1'b1;
          second_next = 1'b0;
          state_next  = S_BASE;
        end
      end
      S_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign res_found      = best_valid;
  assign res_exact      = best_valid && (best_err == '0);
  assign res_divisor    = best_valid ? best_div : '0;
  assign res_oversample = best_valid ? best_osr : '0;
  assign res_achieved   = best_valid ? best_rate : '0;
  assign res_error      = best_valid ? best_err : '0;

`ifndef ASSERT_OFF
  a_found_div : assert property (@(posedge clk) disable iff (rst)
    res_valid && res_found |-> res_divisor != '0)
    else $error("found result with zero divisor");

  a_exact_found : assert property (@(posedge clk) disable iff (rst)
    res_valid && res_exact |-> res_found && res_error == '0 &&
                               res_achieved == CLK_W'(target))
    else $error("exact result inconsistent");

  a_osr_range : assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> osr >= OSR_MIN && osr <= OSR_LAST)
    else $error("oversample setting out of range");

  a_div_done_wait : assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_WAIT_BASE || state == S_WAIT_RATE)
    else $error("divider finished outside a wait state");
`endif

endmodule

[sv/uart_baud_divisor_search_top.sv]
// uart baud divisor search
// cfg: one write channel carrying module_clock_hz, always ready; reset value 24000000.
// din: one target_baud per transfer, taken only while the search engine is idle.
// dout: one result per input transfer: divisor, oversample, achieved_baud,
//   baud_error, found, exact; all fields zero when nothing valid.
// the search walks oversample settings 4 to OVERSAMPLE_MAX, each with a floor
//   divisor and the floor plus one, on one shared bit-serial divider (27 steps).
// per setting: one division for the floor divisor plus one division for
//   each candidate rate; a zero target skips the search entirely,
//   and an exact match ends the search early.
// the result sits in an output register; a new target is taken while it waits,
//   and a finished search holds until that register frees up.
// reset: synchronous active-high rst clears the state machine and output valid
//   and restores the clock register; no clearing pass.
module uart_baud_divisor_search_top #(
  parameter int DIVISOR_WIDTH  = ubds_pkg::DIVISOR_WIDTH_DEF,
  parameter int OVERSAMPLE_MAX = ubds_pkg::OVERSAMPLE_MAX_DEF
) (
  input logic         clk,
  input logic         rst,
  ubds_cfg_if.sink    cfg,
  ubds_in_if.sink     din,
  ubds_out_if.source  dout
);
  import ubds_pkg::*;

  logic [CLK_W-1:0] clock_hz;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                     res_valid;
  logic                     res_ready;
  logic [DIVISOR_WIDTH-1:0] res_divisor;
  logic [OSR_W-1:0]         res_oversample;
  logic [CLK_W-1:0]         res_achieved;
  logic [ERR_W-1:0]         res_error;
  logic                     res_found;
  logic                     res_exact;

  logic                     out_valid;
  logic [DIVISOR_WIDTH-1:0] out_divisor;
  logic [OSR_W-1:0]         out_oversample;
  logic [CLK_W-1:0]         out_achieved;
  logic [ERR_W-1:0]         out_error;
  logic                     out_found;
  logic                     out_exact;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= CLOCK_HZ_RST;
    end else if (cfg.valid) begin
      clock_hz <= cfg.module_clock_hz;
    end
  end

  ubds_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  ubds_seq #(
    .DIVISOR_WIDTH  (DIVISOR_WIDTH),
    .OVERSAMPLE_MAX (OVERSAMPLE_MAX)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (din.valid),
    .in_ready       (din.ready),
    .in_target      (din.target_baud),
    .clock_hz       (clock_hz),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res_divisor    (res_divisor),
    .res_oversample (res_oversample),
    .res_achieved   (res_achieved),
    .res_error      (res_error),
    .res_found      (res_found),
    .res_exact      (res_exact)
  );

  // output register
  assign res_ready = !out_valid || dout.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_divisor    <= res_divisor;
      out_oversample <= res_oversample;
      out_achieved   <= res_achieved;
      out_error      <= res_error;
      out_found      <= res_found;
      out_exact      <= res_exact;
    end
  end

  assign dout.valid         = out_valid;
  assign dout.divisor       = out_divisor;
  assign dout.oversample    = out_oversample;
  assign dout.achieved_baud = out_achieved;
  assign dout.baud_error    = out_error;
  assign dout.found         = out_found;
  assign dout.exact         = out_exact;

endmodule
